### hdl/ccd_pkg.sv
// ----------------------------------------------------------------------------
// ccd_pkg: shared types and constants for the 2D charge deposition block
// Holds command codes, configuration indexes, the job record passed from the
// front end to the back end, and the Q16.16 saturation helper.
// ----------------------------------------------------------------------------
package ccd_pkg;

  localparam int GRID_COLS_DEF = 64;
  localparam int GRID_ROWS_DEF = 64;

  localparam int AMT_W = 34;  // width of one bilinear share

  localparam logic [1:0] CMD_DEPOSIT = 2'd0;
  localparam logic [1:0] CMD_READ    = 2'd1;
  localparam logic [1:0] CMD_CLEAR   = 2'd2;

  localparam logic [2:0] CFG_INV_W  = 3'd0;
  localparam logic [2:0] CFG_INV_H  = 3'd1;
  localparam logic [2:0] CFG_LEN_X  = 3'd2;
  localparam logic [2:0] CFG_LEN_Y  = 3'd3;
  localparam logic [2:0] CFG_COLS   = 3'd4;
  localparam logic [2:0] CFG_ROWS   = 3'd5;

  typedef enum logic [1:0] {
    JK_DEPOSIT,
    JK_READ,
    JK_CLEAR,
    JK_REPORT
  } job_kind_t;

  typedef struct packed {
    job_kind_t                  kind;
    logic                       status;
    logic                       rd_ok;
    logic [3:0][AMT_W-1:0]      amount;
  } job_t;

  typedef struct packed {
    logic [31:0] inv_w;
    logic [31:0] inv_h;
    logic [30:0] len_x;
    logic [30:0] len_y;
    logic [6:0]  cols;
    logic [6:0]  rows;
  } cfg_t;

  // Drops 16 fraction bits of a Q32.32 product and saturates to 32 bits.
  function automatic logic [31:0] q16_sat(input logic [63:0] v);
    q16_sat = (|v[63:48]) ? 32'hFFFF_FFFF : v[47:16];
  endfunction

endpackage

### hdl/ccd_front.sv
// ----------------------------------------------------------------------------
// ccd_front: command intake and deposit arithmetic
// Accepts one command, maps a particle into the grid, works out the four
// bilinear shares over a few multiply stages and hands a job to the queue.
// ----------------------------------------------------------------------------
module ccd_front #(
  parameter int GRID_COLS = ccd_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS = ccd_pkg::GRID_ROWS_DEF,
  parameter int AW        = $clog2(GRID_COLS * GRID_ROWS)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ccd_pkg::cfg_t           cfg,
  input  logic                    hold,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_cmd,
  input  logic [31:0]             in_x,
  input  logic [31:0]             in_y,
  input  logic [31:0]             in_w,
  input  logic [5:0]              in_rc,
  input  logic [5:0]              in_rr,
  output logic                    push_valid,
  input  logic                    push_ready,
  output ccd_pkg::job_t           push_job,
  output logic [3:0][AW-1:0]      push_addr
);

  localparam int CW   = $clog2(GRID_COLS);
  localparam int RW   = $clog2(GRID_ROWS);
  localparam int CNCW = $clog2(GRID_COLS + 1);
  localparam int CNRW = $clog2(GRID_ROWS + 1);

  typedef enum logic [2:0] {
    F_IDLE, F_PREP, F_M1, F_M2, F_M3, F_M4, F_PUSH
  } fstate_t;

  fstate_t state_r, state_nxt;
  logic [1:0]  cmd_r;
  logic [31:0] x_r, y_r, w_r;
  logic [5:0]  rc_r, rr_r;
  logic [30:0] px_r, px_nxt, py_r, py_nxt;
  logic        out_r, out_nxt;
  logic [63:0] pw1_r, pw1_nxt;
  logic [62:0] prodx_r, prodx_nxt, prody_r, prody_nxt;
  logic [31:0] pwa_r, pwa_nxt, pw_r, pw_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [RW-1:0] j_r, j_nxt;
  logic [15:0] hx_r, hx_nxt, hy_r, hy_nxt;
  logic [32:0] tl_r, tl_nxt, th_r, th_nxt;
  ccd_pkg::job_t job_r, job_nxt;
  logic [3:0][AW-1:0] addr_r, addr_nxt;

  logic [32:0] sum_x, sum_y;
  logic [CNCW-1:0] nc, ip1;
  logic [CNRW-1:0] nr, jp1;
  logic [CW-1:0] i1;
  logic [RW-1:0] j1;
  logic [16:0] lx, ly, hx17, hy17;
  logic [49:0] sh_ll, sh_hl, sh_lh, sh_hh;
  logic [48:0] t_l, t_h;
  logic [30:0] idx_x, idx_y;
  logic        rd_ok;

  assign in_ready   = (state_r == F_IDLE) && !hold;
  assign push_valid = (state_r == F_PUSH);
  assign push_job   = job_r;
  assign push_addr  = addr_r;

  always_comb begin
    if (cfg.cols < 7'd2) begin
      nc = CNCW'(2);
    end else if (32'(cfg.cols) > 32'(GRID_COLS)) begin
      nc = CNCW'(GRID_COLS);
    end else begin
      nc = CNCW'(cfg.cols);
    end
    if (cfg.rows < 7'd2) begin
      nr = CNRW'(2);
    end else if (32'(cfg.rows) > 32'(GRID_ROWS)) begin
      nr = CNRW'(GRID_ROWS);
    end else begin
      nr = CNRW'(cfg.rows);
    end
  end

  always_comb begin
    // A negative coordinate gets its length added once.
    sum_x = {x_r[31], x_r} + {2'b00, cfg.len_x};
    sum_y = {y_r[31], y_r} + {2'b00, cfg.len_y};
    idx_x = prodx_r[62:32];
    idx_y = prody_r[62:32];
    ip1   = CNCW'(i_r) + CNCW'(1);
    jp1   = CNRW'(j_r) + CNRW'(1);
    i1    = (ip1 == nc) ? '0 : ip1[CW-1:0];
    j1    = (jp1 == nr) ? '0 : jp1[RW-1:0];
    hx17  = {1'b0, hx_r};
    hy17  = {1'b0, hy_r};
    lx    = 17'h10000 - hx17;
    ly    = 17'h10000 - hy17;
    t_l   = 49'(pw_r) * 49'(lx);
    t_h   = 49'(pw_r) * 49'(hx17);
    sh_ll = 50'(tl_r) * 50'(ly);
    sh_hl = 50'(th_r) * 50'(ly);
    sh_lh = 50'(tl_r) * 50'(hy17);
    sh_hh = 50'(th_r) * 50'(hy17);
    rd_ok = (32'(rc_r) < 32'(GRID_COLS)) && (32'(rr_r) < 32'(GRID_ROWS));
  end

  always_comb begin
    state_nxt = state_r;
    px_nxt    = px_r;
    py_nxt    = py_r;
    out_nxt   = out_r;
    pw1_nxt   = pw1_r;
    prodx_nxt = prodx_r;
    prody_nxt = prody_r;
    pwa_nxt   = pwa_r;
    pw_nxt    = pw_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    hx_nxt    = hx_r;
    hy_nxt    = hy_r;
    tl_nxt    = tl_r;
    th_nxt    = th_r;
    job_nxt   = job_r;
    addr_nxt  = addr_r;
    case (state_r)
      F_IDLE: begin
        if (in_valid && in_ready) begin
          state_nxt = F_PREP;
        end
      end
      F_PREP: begin
        job_nxt.status = 1'b0;
        job_nxt.rd_ok  = 1'b0;
        job_nxt.amount = '0;
        addr_nxt       = '0;
        case (cmd_r)
          ccd_pkg::CMD_DEPOSIT: begin
            px_nxt    = x_r[31] ? sum_x[30:0] : x_r[30:0];
            py_nxt    = y_r[31] ? sum_y[30:0] : y_r[30:0];
            out_nxt   = (x_r[31] && sum_x[32]) || (y_r[31] && sum_y[32]);
            pw1_nxt   = 64'(w_r) * 64'(cfg.inv_w);
            state_nxt = F_M1;
          end
          ccd_pkg::CMD_READ: begin
            job_nxt.kind  = ccd_pkg::JK_READ;
            job_nxt.rd_ok = rd_ok;
            addr_nxt[0]   = rd_ok ? AW'(rr_r) * AW'(GRID_COLS) + AW'(rc_r) : '0;
            state_nxt     = F_PUSH;
          end
          ccd_pkg::CMD_CLEAR: begin
            job_nxt.kind = ccd_pkg::JK_CLEAR;
            state_nxt    = F_PUSH;
          end
          default: begin
            job_nxt.kind = ccd_pkg::JK_REPORT;
            state_nxt    = F_PUSH;
          end
        endcase
      end
      F_M1: begin
        prodx_nxt = 63'(px_r) * 63'(cfg.inv_w);
        prody_nxt = 63'(py_r) * 63'(cfg.inv_h);
        pwa_nxt   = ccd_pkg::q16_sat(pw1_r);
        state_nxt = F_M2;
      end
      F_M2: begin
        pw_nxt = ccd_pkg::q16_sat(64'(pwa_r) * 64'(cfg.inv_h));
        i_nxt  = idx_x[CW-1:0];
        j_nxt  = idx_y[RW-1:0];
        hx_nxt = prodx_r[31:16];
        hy_nxt = prody_r[31:16];
        if (out_r || (idx_x >= 31'(nc)) || (idx_y >= 31'(nr))) begin
          job_nxt.kind   = ccd_pkg::JK_REPORT;
          job_nxt.status = 1'b1;
          state_nxt      = F_PUSH;
        end else begin
          state_nxt = F_M3;
        end
      end
      F_M3: begin
        tl_nxt      = t_l[48:16];
        th_nxt      = t_h[48:16];
        addr_nxt[0] = AW'(j_r) * AW'(GRID_COLS) + AW'(i_r);
        addr_nxt[1] = AW'(j_r) * AW'(GRID_COLS) + AW'(i1);
        addr_nxt[2] = AW'(j1) * AW'(GRID_COLS) + AW'(i_r);
        addr_nxt[3] = AW'(j1) * AW'(GRID_COLS) + AW'(i1);
        state_nxt   = F_M4;
      end
      F_M4: begin
        job_nxt.kind      = ccd_pkg::JK_DEPOSIT;
        job_nxt.amount[0] = sh_ll[49:16];
        job_nxt.amount[1] = sh_hl[49:16];
        job_nxt.amount[2] = sh_lh[49:16];
        job_nxt.amount[3] = sh_hh[49:16];
        state_nxt         = F_PUSH;
      end
      F_PUSH: begin
        if (push_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    if (in_valid && in_ready) begin
      cmd_r <= in_cmd;
      x_r   <= in_x;
      y_r   <= in_y;
      w_r   <= in_w;
      rc_r  <= in_rc;
      rr_r  <= in_rr;
    end
    px_r    <= px_nxt;
    py_r    <= py_nxt;
    out_r   <= out_nxt;
    pw1_r   <= pw1_nxt;
    prodx_r <= prodx_nxt;
    prody_r <= prody_nxt;
    pwa_r   <= pwa_nxt;
    pw_r    <= pw_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    hx_r    <= hx_nxt;
    hy_r    <= hy_nxt;
    tl_r    <= tl_nxt;
    th_r    <= th_nxt;
    job_r   <= job_nxt;
    addr_r  <= addr_nxt;
  end

endmodule

### hdl/ccd_queue.sv
// ----------------------------------------------------------------------------
// ccd_queue: two-entry job queue
// Decouples the front end from the back end so either side can stall alone.
// ----------------------------------------------------------------------------
module ccd_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] slot_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = slot_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wp_nxt  = do_push ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      slot_r[wp_r] <= push_data;
    end
  end

endmodule

### hdl/ccd_back.sv
// ----------------------------------------------------------------------------
// ccd_back: density grid memory and job execution
// Runs read-modify-write accumulation, single-cell reads and clearing sweeps
// on the grid memory, and holds the result register of the output channel.
// ----------------------------------------------------------------------------
module ccd_back #(
  parameter int GRID_COLS = ccd_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS = ccd_pkg::GRID_ROWS_DEF,
  parameter int AW        = $clog2(GRID_COLS * GRID_ROWS)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  ccd_pkg::job_t      pop_job,
  input  logic [3:0][AW-1:0] pop_addr,
  output logic               init_busy,
  output logic               res_valid,
  input  logic               res_ready,
  output logic               res_status,
  output logic [31:0]        res_value
);

  localparam int DEPTH = GRID_COLS * GRID_ROWS;

  typedef enum logic [2:0] {
    B_INIT, B_IDLE, B_DEP, B_RD, B_RDW, B_CLR, B_DONE
  } bstate_t;

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_r;

  bstate_t state_r;
  ccd_pkg::job_t job_r;
  logic [3:0][AW-1:0] addr_r;
  logic [2:0]  step_r;
  logic [AW-1:0] cnt_r;
  logic        st_r;
  logic [31:0] val_r;
  logic        ov_r;
  logic        os_r;
  logic [31:0] odat_r;

  logic          we;
  logic [AW-1:0] wa, ra;
  logic [31:0]   wd;
  logic [34:0]   acc;
  logic [1:0]    wsel;

  assign pop_ready  = (state_r == B_IDLE);
  assign init_busy  = (state_r == B_INIT);
  assign res_valid  = ov_r;
  assign res_status = os_r;
  assign res_value  = odat_r;

  always_comb begin
    wsel = step_r[1:0] - 2'd1;
    acc  = 35'(rdata_r) + 35'(job_r.amount[wsel]);
    we   = 1'b0;
    wa   = addr_r[wsel];
    wd   = (|acc[34:32]) ? 32'hFFFF_FFFF : acc[31:0];
    ra   = addr_r[step_r[1:0]];
    case (state_r)
      B_DEP: we = (step_r != 3'd0);
      B_INIT, B_CLR: begin
        we = 1'b1;
        wa = cnt_r;
        wd = '0;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_r <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_INIT;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      case (state_r)
        B_INIT: begin
          cnt_r <= cnt_r + AW'(1);
          if (cnt_r == AW'(DEPTH - 1)) begin
            state_r <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (pop_valid) begin
            job_r  <= pop_job;
            addr_r <= pop_addr;
            step_r <= 3'd0;
            cnt_r  <= '0;
            st_r   <= pop_job.status;
            val_r  <= '0;
            case (pop_job.kind)
              ccd_pkg::JK_DEPOSIT: state_r <= B_DEP;
              ccd_pkg::JK_READ:    state_r <= B_RD;
              ccd_pkg::JK_CLEAR:   state_r <= B_CLR;
              default:             state_r <= B_DONE;
            endcase
          end
        end
        B_DEP: begin
          // The four cells of one particle are distinct, so a read may
          // overlap the write-back of the previous cell.
          step_r <= step_r + 3'd1;
          if (step_r == 3'd4) begin
            state_r <= B_DONE;
          end
        end
        B_RD: state_r <= B_RDW;
        B_RDW: begin
          val_r   <= job_r.rd_ok ? rdata_r : '0;
          state_r <= B_DONE;
        end
        B_CLR: begin
          cnt_r <= cnt_r + AW'(1);
          if (cnt_r == AW'(DEPTH - 1)) begin
            state_r <= B_DONE;
          end
        end
        B_DONE: begin
          if (!ov_r || res_ready) begin
            ov_r    <= 1'b1;
            os_r    <= st_r;
            odat_r  <= val_r;
            state_r <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
      if (ov_r && res_ready && !((state_r == B_DONE))) begin
        ov_r <= 1'b0;
      end
    end
  end

endmodule

### hdl/cic_charge_deposit_2d.sv
// ----------------------------------------------------------------------------
// cic_charge_deposit_2d: 2D cloud-in-cell charge deposition, Q16.16
// Top level: configuration registers, front end, job queue and back end.
// ----------------------------------------------------------------------------
// In a deposit, the front end runs its five multiply stages and the back end
// makes the four read-modify-write updates, which share the single port pair
// of the grid memory; the two overlap, so the front end can take the next
// deposit while the back end still works on the last. A clear, and the sweep
// after reset, write one cell per cycle over all GRID_COLS*GRID_ROWS cells
// (4096 by default); no item is accepted during the sweep after reset. Each
// command gives exactly one result.
module cic_charge_deposit_2d #(
  parameter int GRID_COLS = ccd_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS = ccd_pkg::GRID_ROWS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [111:0] in_tdata,  // x_pos, y_pos, weight, read_col, read_row
  input  logic [1:0]   in_tuser,  // cmd
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [39:0]  out_tdata  // status, density_value
);

  localparam int AW = $clog2(GRID_COLS * GRID_ROWS);
  localparam int QW = $bits(ccd_pkg::job_t) + 4 * AW;

  ccd_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.inv_w <= 32'd65536;
      cfg_r.inv_h <= 32'd65536;
      cfg_r.len_x <= 31'd4194304;
      cfg_r.len_y <= 31'd4194304;
      cfg_r.cols  <= 7'd64;
      cfg_r.rows  <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        ccd_pkg::CFG_INV_W: cfg_r.inv_w <= cfg_wdata;
        ccd_pkg::CFG_INV_H: cfg_r.inv_h <= cfg_wdata;
        ccd_pkg::CFG_LEN_X: cfg_r.len_x <= cfg_wdata[30:0];
        ccd_pkg::CFG_LEN_Y: cfg_r.len_y <= cfg_wdata[30:0];
        ccd_pkg::CFG_COLS:  cfg_r.cols  <= cfg_wdata[6:0];
        ccd_pkg::CFG_ROWS:  cfg_r.rows  <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  logic               hold;
  logic               f_valid, f_ready, b_valid, b_ready;
  ccd_pkg::job_t      f_job, b_job;
  logic [3:0][AW-1:0] f_addr, b_addr;
  logic [QW-1:0]      b_data;
  logic               res_status;
  logic [31:0]        res_value;

  ccd_front #(
    .GRID_COLS(GRID_COLS),
    .GRID_ROWS(GRID_ROWS),
    .AW(AW)
  ) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .cfg(cfg_r),
    .hold(hold),
    .in_valid(in_tvalid),
    .in_ready(in_tready),
    .in_cmd(in_tuser),
    .in_x(in_tdata[31:0]),
    .in_y(in_tdata[63:32]),
    .in_w(in_tdata[95:64]),
    .in_rc(in_tdata[101:96]),
    .in_rr(in_tdata[107:102]),
    .push_valid(f_valid),
    .push_ready(f_ready),
    .push_job(f_job),
    .push_addr(f_addr)
  );

  ccd_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk(clk),
    .rst_n(rst_n),
    .push_valid(f_valid),
    .push_ready(f_ready),
    .push_data({f_job, f_addr}),
    .pop_valid(b_valid),
    .pop_ready(b_ready),
    .pop_data(b_data)
  );

  assign b_job  = b_data[QW-1:4*AW];
  assign b_addr = b_data[4*AW-1:0];

  ccd_back #(
    .GRID_COLS(GRID_COLS),
    .GRID_ROWS(GRID_ROWS),
    .AW(AW)
  ) u_back (
    .clk(clk),
    .rst_n(rst_n),
    .pop_valid(b_valid),
    .pop_ready(b_ready),
    .pop_job(b_job),
    .pop_addr(b_addr),
    .init_busy(hold),
    .res_valid(out_tvalid),
    .res_ready(out_tready),
    .res_status(res_status),
    .res_value(res_value)
  );

  assign out_tdata = {7'd0, res_value, res_status};

endmodule
